// ===== src/lcd_pkg.sv =====
// Shared types and constants for the character display command stream decoder.
// Holds mode and action codes, register indexes and the result record layout.
// No dependencies.
package lcd_pkg;

    // Number of glyph row bytes that follow the slot byte.
    localparam int GLYPH_ROWS = 8;

    // Argument store geometry.
    localparam int ARG_DEPTH = 8;
    localparam int ARG_IDX_W = 3;
    localparam int ARG_CNT_W = 4;

    // Decoder modes.
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHAR   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CURSOR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GLYPH  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd5;

    // Display actions reported on the result stream.
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_DRAW      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CURSOR    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GLYPH     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BLINK_ON  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BLINK_OFF = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd5;

    // Opcode register map.
    localparam int NUM_OPS  = 6;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_OP_CLEAR  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OP_TEXT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OP_CHAR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OP_CURSOR = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OP_GLYPH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OP_BLINK  = 3'd5;

    // Opcode values after reset, indexed by register number.
    localparam logic [7:0] OP_RESET [NUM_OPS] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};

    // Stream widths.
    localparam int IN_DATA_W  = 8;
    localparam int RESULT_W   = 99;
    localparam int OUT_DATA_W = 104;

    // One decoded result; action sits in the lowest bits.
    typedef struct packed {
        logic [63:0]      glyph_rows;
        logic [7:0]       glyph_slot;
        logic [7:0]       cursor_col;
        logic [7:0]       cursor_row;
        logic [7:0]       char_code;
        logic [ACT_W-1:0] action;
    } result_t;

endpackage

// ===== src/lcd_command_stream_decoder.sv =====
// Top level of the character display command stream decoder.
// Each result is registered: in the result register, or in the skid register on a stall.
// Throughput: one byte per cycle while the skid is empty; bytes ending no command produce nothing.
// A two-entry output stage (result register plus skid register) keeps the input
// open while one result waits. Reset (rst_n, async, active low) returns to idle
// and reloads the opcode registers with their defaults; no clearing pass.
// Depends on lcd_pkg.
module lcd_command_stream_decoder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Command byte stream. s_tdata: [7:0] rx_byte
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lcd_pkg::IN_DATA_W-1:0]         s_tdata,
    // Result stream. m_tdata: [2:0] action, [10:3] char_code, [18:11] cursor_row,
    // [26:19] cursor_col, [34:27] glyph_slot, [98:35] glyph_rows, [103:99] zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lcd_pkg::OUT_DATA_W-1:0]        m_tdata,
    // Opcode register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [4:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [7:0]                       op_reg [lcd_pkg::NUM_OPS];
    logic [lcd_pkg::MODE_W-1:0]       mode_reg;
    logic [lcd_pkg::MODE_W-1:0]       mode_next;
    logic [lcd_pkg::ARG_CNT_W-1:0]    arg_count_reg;
    logic [lcd_pkg::ARG_CNT_W-1:0]    arg_count_next;
    logic [7:0]                       arg_byte_reg [lcd_pkg::ARG_DEPTH];
    logic                             arg_wr;

    lcd_pkg::result_t                 res;
    logic                             res_valid;
    lcd_pkg::result_t                 out_reg;
    logic                             out_valid_reg;
    lcd_pkg::result_t                 skid_reg;
    logic                             skid_valid_reg;

    logic                             in_fire;
    logic                             out_fire;
    logic                             cfg_wr;
    logic [lcd_pkg::REG_IDX_W-1:0]    cfg_idx;
    logic [7:0]                       rx_byte;
    logic [63:0]                      rows;

    assign rx_byte  = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lcd_pkg::OUT_DATA_W - lcd_pkg::RESULT_W){1'b0}}, out_reg};

    // Configuration port: zero wait states, writes land on the access cycle.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcd_pkg::NUM_OPS; i++)
            begin
                op_reg[i] <= lcd_pkg::OP_RESET[i];
            end
        end
        else if (cfg_wr && (cfg_idx < lcd_pkg::REG_IDX_W'(lcd_pkg::NUM_OPS)))
        begin
            op_reg[cfg_idx] <= pwdata[7:0];
        end
    end

    // Register readback; unmapped addresses read as zero.
    always_comb
    begin
        prdata = '0;
        if (cfg_idx < lcd_pkg::REG_IDX_W'(lcd_pkg::NUM_OPS))
        begin
            prdata = {24'd0, op_reg[cfg_idx]};
        end
    end

    // Glyph row assembly: stored rows follow the slot byte, the last row is live.
    always_comb
    begin
        rows = '0;
        for (int i = 0; i < lcd_pkg::ARG_DEPTH; i++)
        begin
            if (i < lcd_pkg::GLYPH_ROWS - 1)
            begin
                rows[8*i +: 8] = arg_byte_reg[lcd_pkg::ARG_IDX_W'(i + 1)];
            end
            else if (i == lcd_pkg::GLYPH_ROWS - 1)
            begin
                rows[8*i +: 8] = rx_byte;
            end
        end
    end

    // Command decode for the byte at the input.
    always_comb
    begin
        mode_next      = mode_reg;
        arg_count_next = arg_count_reg;
        arg_wr         = 1'b0;
        res_valid      = 1'b0;
        res            = '0;
        unique case (mode_reg)
            lcd_pkg::MODE_TEXT:
            begin
                if (rx_byte == 8'd0)
                begin
                    mode_next = lcd_pkg::MODE_IDLE;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.action    = lcd_pkg::ACT_DRAW;
                    res.char_code = rx_byte;
                end
            end
            lcd_pkg::MODE_CHAR:
            begin
                mode_next     = lcd_pkg::MODE_IDLE;
                res_valid     = 1'b1;
                res.action    = lcd_pkg::ACT_DRAW;
                res.char_code = rx_byte;
            end
            lcd_pkg::MODE_CURSOR:
            begin
                if (arg_count_reg != '0)
                begin
                    arg_count_next = '0;
                    mode_next      = lcd_pkg::MODE_IDLE;
                    res_valid      = 1'b1;
                    res.action     = lcd_pkg::ACT_CURSOR;
                    res.cursor_row = arg_byte_reg[0];
                    res.cursor_col = rx_byte;
                end
                else
                begin
                    arg_wr         = 1'b1;
                    arg_count_next = lcd_pkg::ARG_CNT_W'(1);
                end
            end
            lcd_pkg::MODE_GLYPH:
            begin
                if (arg_count_reg >= lcd_pkg::ARG_CNT_W'(lcd_pkg::GLYPH_ROWS))
                begin
                    arg_count_next = '0;
                    mode_next      = lcd_pkg::MODE_IDLE;
                    res_valid      = 1'b1;
                    res.action     = lcd_pkg::ACT_GLYPH;
                    res.glyph_slot = arg_byte_reg[0];
                    res.glyph_rows = rows;
                end
                else
                begin
                    arg_wr         = 1'b1;
                    arg_count_next = arg_count_reg + lcd_pkg::ARG_CNT_W'(1);
                end
            end
            lcd_pkg::MODE_BLINK:
            begin
                mode_next  = lcd_pkg::MODE_IDLE;
                res_valid  = 1'b1;
                res.action = (rx_byte != 8'd0) ? lcd_pkg::ACT_BLINK_ON
                                               : lcd_pkg::ACT_BLINK_OFF;
            end
            default:
            begin
                // Idle: opcode match, first register in map order wins.
                mode_next = lcd_pkg::MODE_IDLE;
                priority if (rx_byte == op_reg[lcd_pkg::REG_OP_CLEAR])
                begin
                    res_valid  = 1'b1;
                    res.action = lcd_pkg::ACT_CLEAR;
                end
                else if (rx_byte == op_reg[lcd_pkg::REG_OP_TEXT])
                begin
                    mode_next = lcd_pkg::MODE_TEXT;
                end
                else if (rx_byte == op_reg[lcd_pkg::REG_OP_CHAR])
                begin
                    mode_next = lcd_pkg::MODE_CHAR;
                end
                else if (rx_byte == op_reg[lcd_pkg::REG_OP_CURSOR])
                begin
                    mode_next      = lcd_pkg::MODE_CURSOR;
                    arg_count_next = '0;
                end
                else if (rx_byte == op_reg[lcd_pkg::REG_OP_GLYPH])
                begin
                    mode_next      = lcd_pkg::MODE_GLYPH;
                    arg_count_next = '0;
                end
                else if (rx_byte == op_reg[lcd_pkg::REG_OP_BLINK])
                begin
                    mode_next = lcd_pkg::MODE_BLINK;
                end
                else
                begin
                    mode_next = lcd_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lcd_pkg::MODE_IDLE;
            arg_count_reg <= '0;
        end
        else if (in_fire)
        begin
            mode_reg      <= mode_next;
            arg_count_reg <= arg_count_next;
        end
    end

    // Argument bytes: slot or row in entry 0, glyph rows in the entries after it.
    always_ff @(posedge clk)
    begin
        if (in_fire && arg_wr)
        begin
            arg_byte_reg[arg_count_reg[lcd_pkg::ARG_IDX_W-1:0]] <= rx_byte;
        end
    end

    // Output stage: result register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    // The skid entry is only ever occupied behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while result register is empty");

    // Filling the skid entry requires a stalled result transaction in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled without output stall");

    // Argument count never passes the glyph row count.
    assert property (@(posedge clk) disable iff (!rst_n)
        arg_count_reg <= lcd_pkg::ARG_CNT_W'(lcd_pkg::GLYPH_ROWS))
        else $error("argument count out of range");

    // Returning to idle always leaves the argument count cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == lcd_pkg::MODE_IDLE) |-> (arg_count_reg == '0))
        else $error("argument count not cleared in idle");

endmodule

// ===== tb/lcd_command_stream_decoder_tb.sv =====
// Self-checking testbench for the character display command stream decoder.
// Drives command bytes and opcode register writes, predicts every display action
// and checks each result transaction field by field. Depends on lcd_pkg.
module lcd_command_stream_decoder_tb;

    localparam int CYCLE_LIMIT = 200000;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // s_tdata: [7:0] rx_byte
    logic [lcd_pkg::IN_DATA_W-1:0]   s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // m_tdata: [2:0] action, [10:3] char_code, [18:11] cursor_row,
    // [26:19] cursor_col, [34:27] glyph_slot, [98:35] glyph_rows, [103:99] zero
    logic [lcd_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [4:0]                      paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // Decoder state mirrored by the predictor.
    logic [lcd_pkg::MODE_W-1:0]      dec_mode  = lcd_pkg::MODE_IDLE;
    logic [lcd_pkg::ARG_CNT_W-1:0]   dec_count = '0;
    logic [7:0]                      dec_args [lcd_pkg::ARG_DEPTH];
    logic [7:0]                      op_value [lcd_pkg::NUM_OPS];

    lcd_pkg::result_t                expected_actions [$];
    lcd_pkg::result_t                seen_result;
    lcd_pkg::result_t                want_result;
    int                              errors         = 0;
    int                              decoded_items  = 0;
    int                              cycles         = 0;
    int                              send_idle_pct  = 0;
    int                              recv_stall_pct = 0;

    lcd_command_stream_decoder u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // Random backpressure on the result stream.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // Decode one command byte; returns the display action it causes, if any.
    function automatic void decode_byte(input logic [7:0] b, output bit emitted,
                                        output bit dropped, output lcd_pkg::result_t res);
        res     = '0;
        emitted = 1'b0;
        dropped = 1'b0;
        case (dec_mode)
            lcd_pkg::MODE_TEXT:
            begin
                if (b == 8'h00)
                    dec_mode = lcd_pkg::MODE_IDLE;
                else
                begin
                    emitted       = 1'b1;
                    res.action    = lcd_pkg::ACT_DRAW;
                    res.char_code = b;
                end
            end
            lcd_pkg::MODE_CHAR:
            begin
                dec_mode      = lcd_pkg::MODE_IDLE;
                emitted       = 1'b1;
                res.action    = lcd_pkg::ACT_DRAW;
                res.char_code = b;
            end
            lcd_pkg::MODE_CURSOR:
            begin
                if (dec_count >= 1)
                begin
                    dec_count      = '0;
                    dec_mode       = lcd_pkg::MODE_IDLE;
                    emitted        = 1'b1;
                    res.action     = lcd_pkg::ACT_CURSOR;
                    res.cursor_row = dec_args[0];
                    res.cursor_col = b;
                end
                else
                begin
                    dec_args[0] = b;
                    dec_count   = 1;
                end
            end
            lcd_pkg::MODE_GLYPH:
            begin
                if (dec_count >= lcd_pkg::GLYPH_ROWS)
                begin
                    // The slot byte comes first; the rows follow it in order.
                    for (int i = 1; i < lcd_pkg::GLYPH_ROWS; i++)
                        res.glyph_rows[8*(i-1) +: 8] = dec_args[i];
                    res.glyph_rows[8*(lcd_pkg::GLYPH_ROWS-1) +: 8] = b;
                    res.glyph_slot = dec_args[0];
                    res.action     = lcd_pkg::ACT_GLYPH;
                    emitted        = 1'b1;
                    dec_count      = '0;
                    dec_mode       = lcd_pkg::MODE_IDLE;
                end
                else
                begin
                    dec_args[dec_count[lcd_pkg::ARG_IDX_W-1:0]] = b;
                    dec_count = dec_count + 1'b1;
                end
            end
            lcd_pkg::MODE_BLINK:
            begin
                dec_mode   = lcd_pkg::MODE_IDLE;
                emitted    = 1'b1;
                res.action = (b != 8'h00) ? lcd_pkg::ACT_BLINK_ON
                                          : lcd_pkg::ACT_BLINK_OFF;
            end
            default:
            begin
                // Opcode lookup; the first matching register wins.
                dec_mode = lcd_pkg::MODE_IDLE;
                if (b == op_value[lcd_pkg::REG_OP_CLEAR])
                begin
                    emitted    = 1'b1;
                    res.action = lcd_pkg::ACT_CLEAR;
                end
                else if (b == op_value[lcd_pkg::REG_OP_TEXT])
                    dec_mode = lcd_pkg::MODE_TEXT;
                else if (b == op_value[lcd_pkg::REG_OP_CHAR])
                    dec_mode = lcd_pkg::MODE_CHAR;
                else if (b == op_value[lcd_pkg::REG_OP_CURSOR])
                begin
                    dec_mode  = lcd_pkg::MODE_CURSOR;
                    dec_count = '0;
                end
                else if (b == op_value[lcd_pkg::REG_OP_GLYPH])
                begin
                    dec_mode  = lcd_pkg::MODE_GLYPH;
                    dec_count = '0;
                end
                else if (b == op_value[lcd_pkg::REG_OP_BLINK])
                    dec_mode = lcd_pkg::MODE_BLINK;
                else
                    dropped = 1'b1;
            end
        endcase
    endfunction

    // Check every result transaction against the oldest predicted action.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result = m_tdata[lcd_pkg::RESULT_W-1:0];
            if (expected_actions.size() == 0)
            begin
                $error("unexpected result transaction: action %0d", seen_result.action);
                errors++;
            end
            else
            begin
                want_result = expected_actions.pop_front();
                compare_field("action", want_result.action, seen_result.action);
                compare_field("char_code", want_result.char_code, seen_result.char_code);
                compare_field("cursor_row", want_result.cursor_row, seen_result.cursor_row);
                compare_field("cursor_col", want_result.cursor_col, seen_result.cursor_col);
                compare_field("glyph_slot", want_result.glyph_slot, seen_result.glyph_slot);
                compare_field("glyph_rows", want_result.glyph_rows, seen_result.glyph_rows);
            end
            compare_field("pad", '0, m_tdata[lcd_pkg::OUT_DATA_W-1:lcd_pkg::RESULT_W]);
        end
    end

    // Send one command byte, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] value);
        lcd_pkg::result_t res;
        bit               emitted;
        bit               dropped;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(value, emitted, dropped, res);
        if (emitted)
            expected_actions.push_back(res);
        if (!dropped)
            decoded_items++;
    endtask

    // Stop sending and wait until every predicted action has arrived.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Read one opcode register and compare it with the mirrored value.
    task automatic check_opcode_reg(input logic [lcd_pkg::REG_IDX_W-1:0] idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 5'(4 * idx);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        compare_field("prdata", {24'h0, op_value[idx]}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write one opcode register, then read it back.
    task automatic write_opcode_reg(input logic [lcd_pkg::REG_IDX_W-1:0] idx,
                                    input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        op_value[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_opcode_reg(idx);
    endtask

    task automatic apply_opcodes(input logic [7:0] clear_op, input logic [7:0] text_op,
                                 input logic [7:0] char_op, input logic [7:0] cursor_op,
                                 input logic [7:0] glyph_op, input logic [7:0] blink_op);
        wait_drain();
        write_opcode_reg(lcd_pkg::REG_OP_CLEAR, clear_op);
        write_opcode_reg(lcd_pkg::REG_OP_TEXT, text_op);
        write_opcode_reg(lcd_pkg::REG_OP_CHAR, char_op);
        write_opcode_reg(lcd_pkg::REG_OP_CURSOR, cursor_op);
        write_opcode_reg(lcd_pkg::REG_OP_GLYPH, glyph_op);
        write_opcode_reg(lcd_pkg::REG_OP_BLINK, blink_op);
    endtask

    // Registers must come out of reset with their default opcodes.
    task automatic test_register_defaults();
        for (int i = 0; i < lcd_pkg::NUM_OPS; i++)
            check_opcode_reg(lcd_pkg::REG_IDX_W'(i));
    endtask

    // Every command at least once, with the byte extremes and the zero-byte cases.
    task automatic test_directed_commands();
        send_byte(op_value[lcd_pkg::REG_OP_CLEAR]);
        send_byte(op_value[lcd_pkg::REG_OP_TEXT]);
        send_byte(8'hFF);
        send_byte(op_value[lcd_pkg::REG_OP_TEXT]);
        send_byte(8'h00);
        send_byte(op_value[lcd_pkg::REG_OP_CHAR]);
        send_byte(8'h00);
        send_byte(op_value[lcd_pkg::REG_OP_CURSOR]);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(op_value[lcd_pkg::REG_OP_GLYPH]);
        send_byte(8'hFF);
        for (int i = 0; i < lcd_pkg::GLYPH_ROWS; i++)
            send_byte(8'(1 << i));
        send_byte(op_value[lcd_pkg::REG_OP_BLINK]);
        send_byte(8'h00);
        send_byte(op_value[lcd_pkg::REG_OP_BLINK]);
        send_byte(8'hFF);
        send_byte(8'h80);
        wait_drain();
    endtask

    // With equal opcodes the clear register wins, then text.
    task automatic test_equal_opcodes();
        apply_opcodes(8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5);
        send_byte(8'hA5);
        wait_drain();
        write_opcode_reg(lcd_pkg::REG_OP_CLEAR, 8'h11);
        send_byte(8'hA5);
        send_byte(8'h41);
        send_byte(8'h00);
        wait_drain();
    endtask

    // Mostly well-formed commands with random arguments, plus noise and
    // commands cut short.
    task automatic test_random_traffic(input int n_items);
        int target;
        int pick;
        int count;
        target = decoded_items + n_items;
        while (decoded_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_byte(op_value[lcd_pkg::REG_OP_CLEAR]);
            else if (pick < 26)
            begin
                send_byte(op_value[lcd_pkg::REG_OP_TEXT]);
                count = $urandom_range(6);
                repeat (count) send_byte(8'($urandom_range(1, 255)));
                if ($urandom_range(19) != 0)
                    send_byte(8'h00);
            end
            else if (pick < 40)
            begin
                send_byte(op_value[lcd_pkg::REG_OP_CHAR]);
                send_byte(8'($urandom_range(255)));
            end
            else if (pick < 55)
            begin
                send_byte(op_value[lcd_pkg::REG_OP_CURSOR]);
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
            end
            else if (pick < 72)
            begin
                // A short glyph lets the following bytes complete it.
                count = ($urandom_range(19) == 0) ? $urandom_range(lcd_pkg::GLYPH_ROWS)
                                                  : lcd_pkg::GLYPH_ROWS + 1;
                send_byte(op_value[lcd_pkg::REG_OP_GLYPH]);
                repeat (count) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 88)
            begin
                send_byte(op_value[lcd_pkg::REG_OP_BLINK]);
                send_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
            end
            else
                send_byte(8'($urandom_range(255)));
        end
        wait_drain();
    endtask

    initial
    begin
        logic [7:0] rand_ops [lcd_pkg::NUM_OPS];
        logic [7:0] fresh;
        bit         clash;

        for (int i = 0; i < lcd_pkg::NUM_OPS; i++)
            op_value[i] = lcd_pkg::OP_RESET[i];
        for (int i = 0; i < lcd_pkg::ARG_DEPTH; i++)
            dec_args[i] = '0;

        send_idle_pct  = 33;
        recv_stall_pct = 49;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed_commands();
        test_equal_opcodes();
        apply_opcodes(8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE);
        test_random_traffic(560);

        // Second phase: the sender idles more often than the receiver stalls.
        send_idle_pct  = 49;
        recv_stall_pct = 33;
        for (int i = 0; i < lcd_pkg::NUM_OPS; i++)
        begin
            do
            begin
                fresh = 8'($urandom_range(255));
                clash = 1'b0;
                for (int j = 0; j < i; j++)
                    if (rand_ops[j] == fresh)
                        clash = 1'b1;
            end
            while (clash);
            rand_ops[i] = fresh;
        end
        apply_opcodes(rand_ops[0], rand_ops[1], rand_ops[2], rand_ops[3], rand_ops[4],
                      rand_ops[5]);
        test_random_traffic(600);

        // Last phase runs at full rate with the default opcodes.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_opcodes(lcd_pkg::OP_RESET[0], lcd_pkg::OP_RESET[1], lcd_pkg::OP_RESET[2],
                      lcd_pkg::OP_RESET[3], lcd_pkg::OP_RESET[4], lcd_pkg::OP_RESET[5]);
        test_random_traffic(600);

        wait_drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
